// ===== rtl/vcsp_pkg.sv =====
// Shared types and constants for the VGM command stream parser.
package vcsp_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [31:0] PCM_BASE_RESET = 32'd71;
    localparam logic [31:0] LOOP_ADDR_RESET = 32'd46401;

    localparam logic [7:0] CMD_PSG_GG   = 8'h4f;
    localparam logic [7:0] CMD_PSG      = 8'h50;
    localparam logic [7:0] CMD_FM_P0    = 8'h52;
    localparam logic [7:0] CMD_FM_P1    = 8'h53;
    localparam logic [7:0] CMD_WAIT_N   = 8'h61;
    localparam logic [7:0] CMD_WAIT_NTSC = 8'h62;
    localparam logic [7:0] CMD_WAIT_PAL = 8'h63;
    localparam logic [7:0] CMD_END      = 8'h66;
    localparam logic [7:0] CMD_SEEK     = 8'he0;
    localparam logic [3:0] CMD_HI_SHORT_WAIT = 4'h7;
    localparam logic [3:0] CMD_HI_DAC   = 4'h8;

    localparam logic [15:0] WAIT_NTSC   = 16'd735;
    localparam logic [15:0] WAIT_PAL    = 16'd882;
    localparam logic [7:0]  DAC_REG     = 8'h2a;

    localparam logic [1:0] KIND_REGW    = 2'd0;
    localparam logic [1:0] KIND_WAIT    = 2'd1;
    localparam logic [1:0] KIND_DAC     = 2'd2;
    localparam logic [1:0] KIND_RESTART = 2'd3;

    localparam int RES_W  = 97;
    localparam int TDATA_W = 104;

    typedef enum logic [2:0] {
        OP_REGW,
        OP_WAIT,
        OP_DAC,
        OP_SEEK,
        OP_RESTART
    } op_t;

    // val: REGW {data, addr} in [15:0], WAIT/DAC samples in [15:0], SEEK offset
    typedef struct packed {
        op_t         op;
        logic        port;
        logic [31:0] val;
    } cmd_op_t;

endpackage

// ===== rtl/vcsp_front.sv =====
// Front end: accepts stream bytes, gathers operands and classifies commands.
module vcsp_front import vcsp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       byte_valid,
    input  logic [7:0] byte_in,
    output logic       op_push,
    output cmd_op_t    op_out
);

    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [31:0] gather_reg, gather_next;
    logic [31:0] shifted;

    assign shifted = {byte_in, gather_reg[31:8]};

    always_comb begin
        phase_next  = phase_reg;
        cmd_next    = cmd_reg;
        gather_next = gather_reg;
        op_push     = 1'b0;
        op_out      = '{op: OP_WAIT, port: 1'b0, val: 32'd0};
        if (byte_valid) begin
            if (phase_reg != 3'd0) begin
                gather_next = shifted;
                phase_next  = phase_reg - 3'd1;
                if (phase_reg == 3'd1) begin
                    unique case (cmd_reg)
                        CMD_FM_P0, CMD_FM_P1: begin
                            op_push     = 1'b1;
                            op_out.op   = OP_REGW;
                            op_out.port = (cmd_reg == CMD_FM_P1);
                            op_out.val  = {16'd0, shifted[31:16]};
                        end
                        CMD_WAIT_N: begin
                            op_push    = 1'b1;
                            op_out.op  = OP_WAIT;
                            op_out.val = {16'd0, shifted[31:16]};
                        end
                        CMD_SEEK: begin
                            op_push    = 1'b1;
                            op_out.op  = OP_SEEK;
                            op_out.val = shifted;
                        end
                        default: ; // PSG operand dropped
                    endcase
                end
            end else begin
                cmd_next    = byte_in;
                gather_next = 32'd0;
                if (byte_in[7:4] == CMD_HI_SHORT_WAIT) begin
                    op_push    = 1'b1;
                    op_out.op  = OP_WAIT;
                    op_out.val = {28'd0, byte_in[3:0]} + 32'd1;
                end else if (byte_in[7:4] == CMD_HI_DAC) begin
                    op_push    = 1'b1;
                    op_out.op  = OP_DAC;
                    op_out.val = {28'd0, byte_in[3:0]};
                end else begin
                    unique case (byte_in)
                        CMD_PSG_GG, CMD_PSG:            phase_next = 3'd1;
                        CMD_FM_P0, CMD_FM_P1, CMD_WAIT_N: phase_next = 3'd2;
                        CMD_SEEK:                        phase_next = 3'd4;
                        CMD_WAIT_NTSC: begin
                            op_push    = 1'b1;
                            op_out.op  = OP_WAIT;
                            op_out.val = {16'd0, WAIT_NTSC};
                        end
                        CMD_WAIT_PAL: begin
                            op_push    = 1'b1;
                            op_out.op  = OP_WAIT;
                            op_out.val = {16'd0, WAIT_PAL};
                        end
                        CMD_END: begin
                            op_push   = 1'b1;
                            op_out.op = OP_RESTART;
                        end
                        default: ; // unknown byte skipped
                    endcase
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= 3'd0;
            cmd_reg    <= 8'd0;
            gather_reg <= 32'd0;
        end else begin
            phase_reg  <= phase_next;
            cmd_reg    <= cmd_next;
            gather_reg <= gather_next;
        end
    end

endmodule

// ===== rtl/vcsp_fifo.sv =====
// Short operation queue between the front end and the back end.
module vcsp_fifo import vcsp_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  cmd_op_t push_data,
    output logic    full,
    input  logic    pop,
    output logic    empty,
    output cmd_op_t head
);

    cmd_op_t             mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CW-1:0]  count_reg;
    logic                do_push, do_pop;

    assign full    = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + FIFO_CW'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - FIFO_CW'(1);
            end
        end
    end

endmodule

// ===== rtl/vcsp_back.sv =====
// Back end: executes queued operations, owns the PCM pointer and the result register.
module vcsp_back import vcsp_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               op_avail,
    input  cmd_op_t            op_in,
    output logic               op_pop,
    input  logic [31:0]        pcm_base,
    input  logic [31:0]        loop_address,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [1:0]         m_tuser,
    output logic [TDATA_W-1:0] m_tdata
);

    logic               out_valid_reg, out_valid_next;
    logic [1:0]         kind_reg, kind_next;
    logic [RES_W-1:0]   res_reg, res_next;
    logic [31:0]        pcm_offset_reg, pcm_offset_next;

    logic        port_v;
    logic [7:0]  addr_v, data_v;
    logic [15:0] wait_v;
    logic [31:0] pcm_v, restart_v;
    logic        emits;

    assign op_pop = op_avail && (!out_valid_reg || m_tready);

    always_comb begin
        port_v    = 1'b0;
        addr_v    = 8'd0;
        data_v    = 8'd0;
        wait_v    = 16'd0;
        pcm_v     = 32'd0;
        restart_v = 32'd0;
        emits     = 1'b1;
        kind_next = kind_reg;
        pcm_offset_next = pcm_offset_reg;
        unique case (op_in.op)
            OP_REGW: begin
                kind_next = KIND_REGW;
                port_v    = op_in.port;
                addr_v    = op_in.val[7:0];
                data_v    = op_in.val[15:8];
            end
            OP_WAIT: begin
                kind_next = KIND_WAIT;
                wait_v    = op_in.val[15:0];
            end
            OP_DAC: begin
                kind_next = KIND_DAC;
                addr_v    = DAC_REG;
                wait_v    = op_in.val[15:0];
                pcm_v     = pcm_base + pcm_offset_reg;
                pcm_offset_next = pcm_offset_reg + 32'd1;
            end
            OP_SEEK: begin
                emits = 1'b0;
                pcm_offset_next = op_in.val;
            end
            OP_RESTART: begin
                kind_next = KIND_RESTART;
                restart_v = loop_address;
            end
            default: emits = 1'b0;
        endcase
        res_next = {restart_v, pcm_v, wait_v, data_v, addr_v, port_v};

        out_valid_next = out_valid_reg && !m_tready;
        if (op_pop && emits) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            pcm_offset_reg <= 32'd0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (op_pop) begin
                pcm_offset_reg <= pcm_offset_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (op_pop && emits) begin
            kind_reg <= kind_next;
            res_reg  <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {{(TDATA_W - RES_W){1'b0}}, res_reg};

    a_dac_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        (op_pop && op_in.op == OP_DAC) |=> pcm_offset_reg == $past(pcm_offset_reg) + 32'd1)
        else $error("PCM pointer did not advance after DAC op");

    a_seek_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (op_pop && op_in.op == OP_SEEK) |=> pcm_offset_reg == $past(op_in.val))
        else $error("seek did not load PCM pointer");

    a_emit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (op_pop && op_in.op != OP_SEEK) |=> out_valid_reg)
        else $error("executed op produced no result");

    a_seek_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (op_pop && op_in.op == OP_SEEK && out_valid_reg && m_tready) |=> !out_valid_reg)
        else $error("seek produced a result");

endmodule

// ===== rtl/vgm_command_stream_parser.sv =====
// VGM command stream parser: takes one stream byte per transfer on s_* and
// returns FM register writes, waits, DAC writes and restarts on m_*. It takes
// a byte in every cycle unless the queue is full; the front end decodes in the
// cycle a byte arrives, the op sits in a 4-entry queue, and the back end
// registers the result. s_tready falls only when the queue is full, which
// happens only while m_tready stays low. Seeks (0xE0) and dropped PSG or
// unknown bytes give no transfer. pcm_base (0x0) and loop_address (0x4) are
// written over the APB port; the user must do so only while idle (unchecked).
module vgm_command_stream_parser import vcsp_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] stream_byte
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [1:0]         m_tuser,   // [1:0] kind
    // [0] port, [8:1] reg_addr, [16:9] reg_data, [32:17] wait_samples,
    // [64:33] pcm_address, [96:65] restart_address, rest zero
    output logic [TDATA_W-1:0] m_tdata,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [31:0] base_reg, loop_reg;
    logic        cfg_wr;
    logic        push, full, empty, pop;
    cmd_op_t     push_op, head_op;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = paddr[2] ? loop_reg : base_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= PCM_BASE_RESET;
            loop_reg <= LOOP_ADDR_RESET;
        end else if (cfg_wr) begin
            if (paddr[2]) begin
                loop_reg <= pwdata;
            end else begin
                base_reg <= pwdata;
            end
        end
    end

    assign s_tready = !full;

    vcsp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (s_tvalid && s_tready),
        .byte_in    (s_tdata),
        .op_push    (push),
        .op_out     (push_op)
    );

    vcsp_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_op),
        .full      (full),
        .pop       (pop),
        .empty     (empty),
        .head      (head_op)
    );

    vcsp_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .op_avail     (!empty),
        .op_in        (head_op),
        .op_pop       (pop),
        .pcm_base     (base_reg),
        .loop_address (loop_reg),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tuser      (m_tuser),
        .m_tdata      (m_tdata)
    );

endmodule

// ===== bench/vgm_command_stream_parser_test.sv =====
// Self-checking testbench for the VGM command stream parser: byte stream in, decoded events out.
`timescale 1ns / 100ps

module vgm_command_stream_parser_test import vcsp_pkg::*;;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 200;
    localparam int PHASES       = 8;
    localparam int PHASE_BYTES  = 195;
    localparam int DRAIN_CYCLES = 12;

    localparam logic [2:0] ADDR_PCM_BASE  = 3'h0;
    localparam logic [2:0] ADDR_LOOP_ADDR = 3'h4;

    typedef struct packed {
        logic [1:0]  kind;
        logic        port;
        logic [7:0]  reg_addr;
        logic [7:0]  reg_data;
        logic [15:0] wait_samples;
        logic [31:0] pcm_address;
        logic [31:0] restart_address;
    } vgm_event_t;

    // how a directed row is checked: by the decoder, no event, or an event typed in
    typedef enum logic [1:0] {
        ROW_MODEL,
        ROW_NONE,
        ROW_GIVEN
    } row_check_t;

    typedef struct {
        logic [7:0] b;
        row_check_t how;
        vgm_event_t ev;
    } stim_row_t;

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [7:0]         s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [1:0]         m_tuser;
    logic [TDATA_W-1:0] m_tdata;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    // decoder state, kept in step with the bytes handed to the block
    logic [2:0]  dec_left;
    logic [7:0]  dec_cmd;
    logic [31:0] dec_gather;
    logic [31:0] dec_offset;
    logic [31:0] dec_pcm_base;
    logic [31:0] dec_loop_addr;

    vgm_event_t events_due[$];
    stim_row_t  directed_rows[$];

    int bad_count   = 0;
    int cycle_count = 0;
    bit in_idle     = 1'b1;
    bit out_idle    = 1'b1;
    bit long_hold   = 1'b0;

    vgm_command_stream_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    function automatic vgm_event_t mk(input logic [1:0] k, input logic p, input logic [7:0] ra,
                                      input logic [7:0] rd, input logic [15:0] ws,
                                      input logic [31:0] pa, input logic [31:0] rs);
        vgm_event_t ev;
        ev.kind            = k;
        ev.port            = p;
        ev.reg_addr        = ra;
        ev.reg_data        = rd;
        ev.wait_samples    = ws;
        ev.pcm_address     = pa;
        ev.restart_address = rs;
        return ev;
    endfunction

    // Advances the decoder by one stream byte; returns 1 when the byte completes an event.
    function automatic bit decode_byte(input logic [7:0] b, output vgm_event_t ev);
        ev = '0;
        if (dec_left != 3'd0) begin
            // operands shift in from the top, little-endian
            dec_gather = {b, dec_gather[31:8]};
            dec_left   = dec_left - 3'd1;
            if (dec_left != 3'd0)
                return 1'b0;
            case (dec_cmd)
                CMD_FM_P0, CMD_FM_P1: begin
                    ev.kind     = KIND_REGW;
                    ev.port     = (dec_cmd == CMD_FM_P1);
                    ev.reg_addr = dec_gather[23:16];
                    ev.reg_data = dec_gather[31:24];
                    return 1'b1;
                end
                CMD_WAIT_N: begin
                    ev.kind         = KIND_WAIT;
                    ev.wait_samples = dec_gather[31:16];
                    return 1'b1;
                end
                CMD_SEEK: dec_offset = dec_gather;
                default: ;
            endcase
            return 1'b0;
        end

        dec_cmd    = b;
        dec_gather = '0;
        if (b[7:4] == CMD_HI_SHORT_WAIT) begin
            ev.kind         = KIND_WAIT;
            ev.wait_samples = {12'd0, b[3:0]} + 16'd1;
            return 1'b1;
        end
        if (b[7:4] == CMD_HI_DAC) begin
            ev.kind         = KIND_DAC;
            ev.reg_addr     = DAC_REG;
            ev.wait_samples = {12'd0, b[3:0]};
            ev.pcm_address  = dec_pcm_base + dec_offset;
            dec_offset      = dec_offset + 32'd1;
            return 1'b1;
        end
        case (b)
            CMD_PSG_GG, CMD_PSG:              dec_left = 3'd1;
            CMD_FM_P0, CMD_FM_P1, CMD_WAIT_N: dec_left = 3'd2;
            CMD_SEEK:                         dec_left = 3'd4;
            CMD_WAIT_NTSC: begin
                ev.kind         = KIND_WAIT;
                ev.wait_samples = WAIT_NTSC;
            end
            CMD_WAIT_PAL: begin
                ev.kind         = KIND_WAIT;
                ev.wait_samples = WAIT_PAL;
            end
            CMD_END: begin
                ev.kind            = KIND_RESTART;
                ev.restart_address = dec_loop_addr;
            end
            default: ;
        endcase
        return (b == CMD_WAIT_NTSC || b == CMD_WAIT_PAL || b == CMD_END);
    endfunction

    task automatic add_row(input logic [7:0] b, input row_check_t how, input vgm_event_t ev);
        stim_row_t row;
        row.b   = b;
        row.how = how;
        row.ev  = ev;
        directed_rows.push_back(row);
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic feed_byte(input logic [7:0] b, input row_check_t how,
                             input vgm_event_t given);
        vgm_event_t ev;
        bit         has_ev;
        int         gap;
        has_ev = decode_byte(b, ev);
        if (how == ROW_GIVEN)
            events_due.push_back(given);
        else if (how == ROW_MODEL && has_ev)
            events_due.push_back(ev);
        gap = in_idle ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // One well-formed command with random operands, or a stray byte now and then.
    task automatic feed_random_command(output int counted);
        logic [7:0]  cmd;
        logic [3:0]  lo;
        logic [31:0] operand;
        int          n_ops;
        int          pick;
        pick    = $urandom_range(0, 99);
        lo      = 4'($urandom_range(0, 15));
        operand = $urandom;
        n_ops   = 0;
        counted = 0;
        if (pick < 28) begin
            cmd   = $urandom_range(0, 1) ? CMD_FM_P1 : CMD_FM_P0;
            n_ops = 2;
        end else if (pick < 38) begin
            cmd   = CMD_WAIT_N;
            n_ops = 2;
        end else if (pick < 46) begin
            case ($urandom_range(0, 2))
                0:       cmd = CMD_WAIT_NTSC;
                1:       cmd = CMD_WAIT_PAL;
                default: cmd = CMD_END;
            endcase
        end else if (pick < 56) begin
            cmd = {CMD_HI_SHORT_WAIT, lo};
        end else if (pick < 76) begin
            cmd = {CMD_HI_DAC, lo};
        end else if (pick < 82) begin
            cmd   = CMD_SEEK;
            n_ops = 4;
            // offsets near the top make the pointer and the address wrap
            case ($urandom_range(0, 2))
                0:       operand = $urandom;
                1:       operand = 32'hffff_ffff - $urandom_range(0, 7);
                default: operand = $urandom_range(0, 15);
            endcase
        end else if (pick < 88) begin
            cmd   = $urandom_range(0, 1) ? CMD_PSG : CMD_PSG_GG;
            n_ops = 1;
        end else begin
            cmd = 8'($urandom_range(0, 255));
            feed_byte(cmd, ROW_MODEL, '0);
            counted = 1;
            return;
        end
        feed_byte(cmd, ROW_MODEL, '0);
        for (int i = 0; i < n_ops; i++)
            feed_byte(operand[8*i +: 8], ROW_MODEL, '0);
        counted = 1 + n_ops;
    endtask

    // Write, then read back in the next transfer; called at a falling edge.
    task automatic write_config(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        @(negedge aclk);
        case (addr)
            ADDR_PCM_BASE:  dec_pcm_base  = value;
            ADDR_LOOP_ADDR: dec_loop_addr = value;
            default: ;
        endcase
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        if (prdata !== value) begin
            $display("%0t: readback at %h: expected %h, got %h", $time, addr, value, prdata);
            bad_count++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Seeks and dropped bytes leave nothing to wait for, so give the pipeline a few more cycles.
    task automatic drain_events;
        while (events_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
            bad_count++;
        end
    endtask

    always @(posedge aclk) begin : result_check
        vgm_event_t got;
        vgm_event_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind            = m_tuser;
            got.port            = m_tdata[0];
            got.reg_addr        = m_tdata[8:1];
            got.reg_data        = m_tdata[16:9];
            got.wait_samples    = m_tdata[32:17];
            got.pcm_address     = m_tdata[64:33];
            got.restart_address = m_tdata[96:65];
            if (events_due.size() == 0) begin
                $display("%0t: unexpected result: expected none, got kind %0d tdata %h",
                         $time, m_tuser, m_tdata);
                bad_count++;
            end else begin
                want = events_due.pop_front();
                check_field("kind", 32'(want.kind), 32'(got.kind));
                check_field("port", 32'(want.port), 32'(got.port));
                check_field("reg_addr", 32'(want.reg_addr), 32'(got.reg_addr));
                check_field("reg_data", 32'(want.reg_data), 32'(got.reg_data));
                check_field("wait_samples", 32'(want.wait_samples), 32'(got.wait_samples));
                check_field("pcm_address", want.pcm_address, got.pcm_address);
                check_field("restart_address", want.restart_address, got.restart_address);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("vgm_command_stream_parser regression: fail");
            $finish;
        end
    end

    initial begin : result_sink
        int stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            // long back-pressure: the queue fills and the input stalls
            if (long_hold) begin
                long_hold = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            stall = out_idle ? $urandom_range(0, 14) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid)
                @(posedge aclk);
            @(negedge aclk);
        end
    end

    initial begin : stimulus
        int          counted;
        int          n;
        logic [31:0] cfg_base;
        logic [31:0] cfg_loop;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;

        dec_left      = '0;
        dec_cmd       = '0;
        dec_gather    = '0;
        dec_offset    = '0;
        dec_pcm_base  = 32'd71;
        dec_loop_addr = 32'd46401;

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset values of pcm_base and loop_address apply here
        add_row(CMD_END, ROW_GIVEN, mk(KIND_RESTART, 1'b0, 8'h00, 8'h00, 16'd0, 32'd0, 32'd46401));
        add_row({CMD_HI_DAC, 4'h0}, ROW_GIVEN,
                mk(KIND_DAC, 1'b0, DAC_REG, 8'h00, 16'd0, 32'd71, 32'd0));
        add_row({CMD_HI_DAC, 4'h1}, ROW_MODEL, '0);
        add_row({CMD_HI_SHORT_WAIT, 4'h0}, ROW_GIVEN,
                mk(KIND_WAIT, 1'b0, 8'h00, 8'h00, 16'd1, 32'd0, 32'd0));
        add_row({CMD_HI_SHORT_WAIT, 4'hf}, ROW_GIVEN,
                mk(KIND_WAIT, 1'b0, 8'h00, 8'h00, 16'd16, 32'd0, 32'd0));
        add_row(CMD_WAIT_NTSC, ROW_GIVEN, mk(KIND_WAIT, 1'b0, 8'h00, 8'h00, 16'd735, 32'd0, 32'd0));
        add_row(CMD_WAIT_PAL, ROW_GIVEN, mk(KIND_WAIT, 1'b0, 8'h00, 8'h00, 16'd882, 32'd0, 32'd0));
        add_row(CMD_FM_P0, ROW_NONE, '0);
        add_row(8'h00, ROW_NONE, '0);
        add_row(8'hff, ROW_GIVEN, mk(KIND_REGW, 1'b0, 8'h00, 8'hff, 16'd0, 32'd0, 32'd0));
        add_row(CMD_FM_P1, ROW_NONE, '0);
        add_row(8'hff, ROW_NONE, '0);
        add_row(8'h00, ROW_GIVEN, mk(KIND_REGW, 1'b1, 8'hff, 8'h00, 16'd0, 32'd0, 32'd0));
        add_row(CMD_WAIT_N, ROW_NONE, '0);
        add_row(8'hff, ROW_NONE, '0);
        add_row(8'hff, ROW_GIVEN, mk(KIND_WAIT, 1'b0, 8'h00, 8'h00, 16'hffff, 32'd0, 32'd0));
        // seek to the top offset: the next DAC address wraps, then the pointer wraps to zero
        add_row(CMD_SEEK, ROW_MODEL, '0);
        add_row(8'hff, ROW_MODEL, '0);
        add_row(8'hff, ROW_MODEL, '0);
        add_row(8'hff, ROW_MODEL, '0);
        add_row(8'hff, ROW_MODEL, '0);
        add_row({CMD_HI_DAC, 4'hf}, ROW_GIVEN,
                mk(KIND_DAC, 1'b0, DAC_REG, 8'h00, 16'd15, 32'd70, 32'd0));
        // PSG operands that look like commands are dropped
        add_row(CMD_PSG_GG, ROW_NONE, '0);
        add_row(CMD_END, ROW_NONE, '0);
        add_row(CMD_PSG, ROW_NONE, '0);
        add_row({CMD_HI_DAC, 4'h0}, ROW_NONE, '0);
        add_row(8'h00, ROW_NONE, '0);

        foreach (directed_rows[i])
            feed_byte(directed_rows[i].b, directed_rows[i].how, directed_rows[i].ev);
        s_tvalid <= 1'b0;

        for (int phase = 0; phase < PHASES; phase++) begin
            drain_events();
            case (phase)
                0: begin
                    cfg_base = '0;
                    cfg_loop = '1;
                end
                1: begin
                    cfg_base = '1;
                    cfg_loop = '0;
                end
                2: begin
                    cfg_base = 32'hffff_fff0;
                    cfg_loop = $urandom;
                end
                default: begin
                    cfg_base = $urandom;
                    cfg_loop = $urandom;
                end
            endcase
            write_config(ADDR_PCM_BASE, cfg_base);
            write_config(ADDR_LOOP_ADDR, cfg_loop);
            in_idle  = (phase % 4 == 0) || (phase % 4 == 2);
            out_idle = (phase % 4 == 0) || (phase % 4 == 3);
            if (phase == 5)
                long_hold = 1'b1;
            counted = 0;
            while (counted < PHASE_BYTES) begin
                feed_random_command(n);
                counted += n;
            end
            s_tvalid <= 1'b0;
        end

        drain_events();
        if (bad_count == 0)
            $display("vgm_command_stream_parser regression: pass");
        else
            $display("vgm_command_stream_parser regression: fail");
        $finish;
    end

endmodule
